// ===== sv/bole_pkg.sv =====
// ----------------------------------------------------------------------------
// bole_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int OP_W     = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST = 4'd0,
        OP_INS_LAST  = 4'd1,
        OP_EXISTS    = 4'd2,
        OP_RM_VALUE  = 4'd3,
        OP_GET_POS   = 4'd4,
        OP_RM_POS    = 4'd5,
        OP_RM_FIRST  = 4'd6,
        OP_RM_LAST   = 4'd7,
        OP_COUNT     = 4'd8,
        OP_SORT      = 4'd9,
        OP_CLEAR     = 4'd10
    } op_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INIT_I_CNT,
        CMD_WR_TAIL,
        CMD_INIT_I_ZERO,
        CMD_RD_TARGET,
        CMD_SET_OK,
        CMD_SORT_START,
        CMD_CLEAR,
        CMD_WR_HEAD,
        CMD_RD_IM1,
        CMD_WR_I_DEC,
        CMD_RD_I,
        CMD_INC_I,
        CMD_CAPTURE,
        CMD_CAPTURE_DEC,
        CMD_RD_I1,
        CMD_DEC_CNT,
        CMD_WR_I_INC,
        CMD_LOAD_CUR,
        CMD_WR_I_CUR,
        CMD_RD_J,
        CMD_SWAP_J
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            full;
        logic            target_ok;
        logic            i_zero;
        logic            i_done;
        logic            i1_lt_cnt;
        logic            j_done;
        logic            match;
    } dp_status_t;

endpackage

// ===== sv/bounded_ordered_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top
// Ordered list of up to CAPACITY signed 32-bit values driven by requests.
//
// One request transfer on the s_axis side gives exactly one result transfer
// on the m_axis side. The request names the operation in tuser; the value
// and position travel in tdata. The result carries ok in tuser and the
// value and the length after the operation in tdata.
// Count, clear and insert last go straight from dispatch to the result;
// insert first, search and removal shifts walk the entries one by one;
// sort compares each of the n entries with all later ones (one read port walk).
// Requests are taken one at a time; s_axis_tready is high while the
// sequencer is idle, also while a finished result waits in the output
// register. A stalled receiver holds the result and stops the next
// request only once that one is done.
// Reset empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top
    import bole_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // item_value[31:0], position[37:32]
    input  logic [4:0]             s_axis_tuser,  // opcode[3:0], sort_up[4]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_value[31:0], length[38:32]
    output logic [0:0]             m_axis_tuser   // ok[0]
);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic              ok;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  length;

    bole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    bole_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_opcode   (s_axis_tuser[OP_W-1:0]),
        .in_value    (s_axis_tdata[DATA_W-1:0]),
        .in_position (s_axis_tdata[DATA_W+POS_W-1:DATA_W]),
        .in_sort_up  (s_axis_tuser[OP_W]),
        .status      (status),
        .out_ok      (ok),
        .out_value   (value),
        .out_length  (length)
    );

    assign m_axis_tdata = {(OUT_TDATA_W-DATA_W-CNT_W)'(0), length, value};
    assign m_axis_tuser = ok;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (length <= CNT_W'(CAPACITY)))
        else $error("length above capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !ok |-> (value == '0))
        else $error("failed request with nonzero value");

endmodule

// ===== sv/bole_ram.sv =====
// ----------------------------------------------------------------------------
// bole_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/bole_datapath.sv =====
// ----------------------------------------------------------------------------
// bole_datapath
// Entry storage, length counter, walk indexes, compare and result registers.
// ----------------------------------------------------------------------------
module bole_datapath
    import bole_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    input  logic [OP_W-1:0]       in_opcode,
    input  logic [DATA_W-1:0]     in_value,
    input  logic [POS_W-1:0]      in_position,
    input  logic                  in_sort_up,
    output dp_status_t            status,
    output logic                  out_ok,
    output logic [DATA_W-1:0]     out_value,
    output logic [CNT_W-1:0]      out_length
);

    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              up_reg, up_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [DATA_W-1:0] cur_reg, cur_next;
    logic              ok_reg, ok_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              oko_reg;
    logic [DATA_W-1:0] outv_reg;
    logic [CNT_W-1:0]  outl_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;
    logic [CNT_W-1:0]  target;
    logic              swap;

    bole_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        priority if (op_reg == OP_RM_FIRST)
            target = '0;
        else if (op_reg == OP_RM_LAST)
            target = cnt_reg - CNT_W'(1);
        else
            target = CNT_W'(pos_reg);
    end

    assign swap = up_reg ? ($signed(cur_reg) > $signed(rdata))
                         : ($signed(rdata) > $signed(cur_reg));

    always_comb
    begin
        status.opcode    = op_reg;
        status.full      = (cnt_reg == CNT_W'(CAPACITY));
        status.target_ok = (op_reg == OP_RM_FIRST || op_reg == OP_RM_LAST)
                           ? (cnt_reg != '0) : (CNT_W'(pos_reg) < cnt_reg);
        status.i_zero    = (i_reg == '0);
        status.i_done    = (i_reg >= cnt_reg);
        status.i1_lt_cnt = ((i_reg + CNT_W'(1)) < cnt_reg);
        status.j_done    = (j_reg >= cnt_reg);
        status.match     = (rdata == val_reg);
    end

    always_comb
    begin
        op_next  = op_reg;
        val_next = val_reg;
        pos_next = pos_reg;
        up_next  = up_reg;
        cnt_next = cnt_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        cur_next = cur_reg;
        ok_next  = ok_reg;
        res_next = res_reg;
        we       = 1'b0;
        waddr    = i_reg[ADDR_W-1:0];
        wdata    = rdata;
        raddr    = i_reg[ADDR_W-1:0];
        unique case (cmd.op)
            CMD_NONE:
            begin
            end
            CMD_LOAD:
            begin
                op_next  = in_opcode;
                val_next = in_value;
                pos_next = in_position;
                up_next  = in_sort_up;
                ok_next  = 1'b0;
                res_next = '0;
            end
            CMD_INIT_I_CNT:  i_next = cnt_reg;
            CMD_WR_TAIL:
            begin
                we       = 1'b1;
                waddr    = cnt_reg[ADDR_W-1:0];
                wdata    = val_reg;
                cnt_next = cnt_reg + CNT_W'(1);
                ok_next  = 1'b1;
            end
            CMD_INIT_I_ZERO: i_next = '0;
            CMD_RD_TARGET:
            begin
                raddr  = target[ADDR_W-1:0];
                i_next = target;
            end
            CMD_SET_OK:      ok_next = 1'b1;
            CMD_SORT_START:
            begin
                ok_next = 1'b1;
                i_next  = '0;
            end
            CMD_CLEAR:
            begin
                cnt_next = '0;
                ok_next  = 1'b1;
            end
            CMD_WR_HEAD:
            begin
                we       = 1'b1;
                waddr    = '0;
                wdata    = val_reg;
                cnt_next = cnt_reg + CNT_W'(1);
                ok_next  = 1'b1;
            end
            CMD_RD_IM1:      raddr = ADDR_W'(i_reg - CNT_W'(1));
            CMD_WR_I_DEC:
            begin
                we     = 1'b1;
                i_next = i_reg - CNT_W'(1);
            end
            CMD_RD_I:        raddr = i_reg[ADDR_W-1:0];
            CMD_INC_I:       i_next = i_reg + CNT_W'(1);
            CMD_CAPTURE:
            begin
                res_next = rdata;
                ok_next  = 1'b1;
            end
            CMD_CAPTURE_DEC:
            begin
                res_next = rdata;
                ok_next  = 1'b1;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            CMD_RD_I1:       raddr = ADDR_W'(i_reg + CNT_W'(1));
            CMD_DEC_CNT:     cnt_next = cnt_reg - CNT_W'(1);
            CMD_WR_I_INC:
            begin
                we     = 1'b1;
                i_next = i_reg + CNT_W'(1);
            end
            CMD_LOAD_CUR:
            begin
                cur_next = rdata;
                j_next   = i_reg + CNT_W'(1);
            end
            CMD_WR_I_CUR:
            begin
                we     = 1'b1;
                wdata  = cur_reg;
                i_next = i_reg + CNT_W'(1);
            end
            CMD_RD_J:        raddr = j_reg[ADDR_W-1:0];
            CMD_SWAP_J:
            begin
                waddr  = j_reg[ADDR_W-1:0];
                wdata  = cur_reg;
                we     = swap;
                j_next = j_reg + CNT_W'(1);
                if (swap)
                begin
                    cur_next = rdata;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
        up_reg  <= up_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        cur_reg <= cur_next;
        ok_reg  <= ok_next;
        res_reg <= res_next;
        if (cmd.out_load)
        begin
            oko_reg  <= ok_reg;
            outv_reg <= res_reg;
            outl_reg <= cnt_reg;
        end
    end

    assign out_ok     = oko_reg;
    assign out_value  = outv_reg;
    assign out_length = outl_reg;

endmodule

// ===== sv/bole_ctrl.sv =====
// ----------------------------------------------------------------------------
// bole_ctrl
// Request sequencer: walks each operation over the entry store and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module bole_ctrl
    import bole_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00000000000001,
        ST_DISPATCH  = 14'b00000000000010,
        ST_SHUP_CHK  = 14'b00000000000100,
        ST_SHUP_WR   = 14'b00000000001000,
        ST_FIND_CHK  = 14'b00000000010000,
        ST_FIND_CMP  = 14'b00000000100000,
        ST_FETCH_CAP = 14'b00000001000000,
        ST_SHDN_CHK  = 14'b00000010000000,
        ST_SHDN_WR   = 14'b00000100000000,
        ST_SORT_CHK  = 14'b00001000000000,
        ST_SORT_LDI  = 14'b00010000000000,
        ST_SORT_JCHK = 14'b00100000000000,
        ST_SORT_CMP  = 14'b01000000000000,
        ST_DONE      = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg & ~out_ready;
        cmd.op       = CMD_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_DONE;
                unique case (status.opcode)
                    OP_INS_FIRST:
                    begin
                        if (!status.full)
                        begin
                            cmd.op     = CMD_INIT_I_CNT;
                            state_next = ST_SHUP_CHK;
                        end
                    end
                    OP_INS_LAST:
                    begin
                        if (!status.full)
                        begin
                            cmd.op = CMD_WR_TAIL;
                        end
                    end
                    OP_EXISTS, OP_RM_VALUE:
                    begin
                        cmd.op     = CMD_INIT_I_ZERO;
                        state_next = ST_FIND_CHK;
                    end
                    OP_GET_POS, OP_RM_POS, OP_RM_FIRST, OP_RM_LAST:
                    begin
                        if (status.target_ok)
                        begin
                            cmd.op     = CMD_RD_TARGET;
                            state_next = ST_FETCH_CAP;
                        end
                    end
                    OP_COUNT: cmd.op = CMD_SET_OK;
                    OP_SORT:
                    begin
                        cmd.op     = CMD_SORT_START;
                        state_next = ST_SORT_CHK;
                    end
                    OP_CLEAR: cmd.op = CMD_CLEAR;
                    default:
                    begin
                    end
                endcase
            end
            ST_SHUP_CHK:
            begin
                if (status.i_zero)
                begin
                    cmd.op     = CMD_WR_HEAD;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = CMD_RD_IM1;
                    state_next = ST_SHUP_WR;
                end
            end
            ST_SHUP_WR:
            begin
                cmd.op     = CMD_WR_I_DEC;
                state_next = ST_SHUP_CHK;
            end
            ST_FIND_CHK:
            begin
                if (status.i_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = CMD_RD_I;
                    state_next = ST_FIND_CMP;
                end
            end
            ST_FIND_CMP:
            begin
                if (status.match)
                begin
                    cmd.op     = CMD_SET_OK;
                    state_next = (status.opcode == OP_RM_VALUE) ? ST_SHDN_CHK : ST_DONE;
                end
                else
                begin
                    cmd.op     = CMD_INC_I;
                    state_next = ST_FIND_CHK;
                end
            end
            ST_FETCH_CAP:
            begin
                priority if (status.opcode == OP_RM_LAST)
                begin
                    cmd.op     = CMD_CAPTURE_DEC;
                    state_next = ST_DONE;
                end
                else if (status.opcode == OP_GET_POS)
                begin
                    cmd.op     = CMD_CAPTURE;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = CMD_CAPTURE;
                    state_next = ST_SHDN_CHK;
                end
            end
            ST_SHDN_CHK:
            begin
                if (status.i1_lt_cnt)
                begin
                    cmd.op     = CMD_RD_I1;
                    state_next = ST_SHDN_WR;
                end
                else
                begin
                    cmd.op     = CMD_DEC_CNT;
                    state_next = ST_DONE;
                end
            end
            ST_SHDN_WR:
            begin
                cmd.op     = CMD_WR_I_INC;
                state_next = ST_SHDN_CHK;
            end
            ST_SORT_CHK:
            begin
                if (status.i_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = CMD_RD_I;
                    state_next = ST_SORT_LDI;
                end
            end
            ST_SORT_LDI:
            begin
                cmd.op     = CMD_LOAD_CUR;
                state_next = ST_SORT_JCHK;
            end
            ST_SORT_JCHK:
            begin
                if (status.j_done)
                begin
                    cmd.op     = CMD_WR_I_CUR;
                    state_next = ST_SORT_CHK;
                end
                else
                begin
                    cmd.op     = CMD_RD_J;
                    state_next = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP:
            begin
                cmd.op     = CMD_SWAP_J;
                state_next = ST_SORT_JCHK;
            end
            ST_DONE:
            begin
                if (!valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule
